[rtl/core/bve_pkg.sv]
// Package with shared types and constants of the bounded vector engine.
`default_nettype none
package bve_pkg;
   localparam int Depth = 256;
   localparam int AddrW = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);
   localparam int LenW  = 9;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_INSERT = 2'd2,
      FUNC_DELETE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NOKEY = 2'd3
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] key;
      logic [31:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REPLY
   } state_type;
endpackage
`default_nettype wire

[rtl/core/bve_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module bve_ram #(
   parameter int Width = 32,
   parameter int Words = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Words)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Words];

   // Write at the address; the read is registered, so read data lands in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

[rtl/core/bve_front.sv]
// Command queue between the request channel and the executor.
`default_nettype none
module bve_front
   import bve_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire cmd_type req_cmd,
   output logic         cmd_valid,
   input  wire logic    cmd_take,
   output cmd_type      cmd_out
);
   cmd_type    slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_valid && cmd_take;
   assign cmd_out    = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // Two-entry queue pointers and storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
      end
      if (push) slot_ff[wp_ff] <= req_cmd;
   end
endmodule
`default_nettype wire

[rtl/core/bve_back.sv]
// Executor: searches and shifts the vector store and produces results.
`default_nettype none
module bve_back
   import bve_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_take,
   input  wire cmd_type cmd_in,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output status_type   rsp_status,
   output logic [LenW-1:0] rsp_length
);
   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in_r;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] pos_ff, pos_in;
   status_type  st_ff, st_in;
   logic        rdv_ff, rdv_in;
   logic        wr_en;
   logic [CntW-1:0] addr;
   logic [31:0] wr_data, rd_data;

   bve_ram #(.Width(32), .Words(Depth)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr[AddrW-1:0]),
      .wr_data(wr_data), .rd_data(rd_data)
   );

   assign rsp_tvalid = (state_ff == S_REPLY);
   assign rsp_status = st_ff;
   assign rsp_length = LenW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cmd_ff  <= cmd_in_r;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      st_ff   <= st_in;
      rdv_ff  <= rdv_in;
   end

   // Sequencer: linear search with one read a cycle, then shift by read/write pairs.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd_in_r = cmd_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      st_in    = st_ff;
      rdv_in   = 1'b0;
      cmd_take = 1'b0;
      wr_en    = 1'b0;
      addr     = idx_ff;
      wr_data  = cmd_ff.value;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in_r = cmd_in;
               idx_in   = '0;
               st_in    = ST_DONE;
               state_in = S_REPLY;
               unique case (cmd_in.func)
                  FUNC_PUSH: begin
                     if (count_ff == CntW'(Depth)) st_in = ST_FULL;
                     else begin
                        wr_en    = 1'b1;
                        addr     = count_ff;
                        wr_data  = cmd_in.value;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) st_in = ST_EMPTY;
                     else count_in = count_ff - CntW'(1);
                  end
                  FUNC_INSERT: begin
                     if (count_ff == CntW'(Depth)) st_in = ST_FULL;
                     else if (count_ff == '0) st_in = ST_NOKEY;
                     else begin
                        addr = '0; rdv_in = 1'b1; idx_in = CntW'(1);
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     if (count_ff == '0) st_in = ST_NOKEY;
                     else begin
                        addr = '0; rdv_in = 1'b1; idx_in = CntW'(1);
                        state_in = S_SEARCH;
                     end
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // rd_data holds entry idx_ff-1 when rdv_ff is set.
            if (rdv_ff && rd_data == cmd_ff.key) begin
               pos_in = idx_ff - CntW'(1);
               if (cmd_ff.func == FUNC_INSERT) begin
                  // Move words from the end down toward pos+1.
                  idx_in   = count_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  idx_in   = idx_ff;
                  state_in = S_SHIFT_RD;
               end
            end else if (idx_ff == count_ff) begin
               st_in    = ST_NOKEY;
               state_in = S_REPLY;
            end else begin
               addr   = idx_ff;
               rdv_in = 1'b1;
               idx_in = idx_ff + CntW'(1);
            end
         end
         S_SHIFT_RD: begin
            if (cmd_ff.func == FUNC_INSERT) begin
               if (idx_ff == pos_ff + CntW'(1)) begin
                  wr_en    = 1'b1;
                  addr     = idx_ff;
                  wr_data  = cmd_ff.value;
                  count_in = count_ff + CntW'(1);
                  state_in = S_REPLY;
               end else begin
                  addr     = idx_ff - CntW'(1);
                  state_in = S_SHIFT_WR;
               end
            end else begin
               if (idx_ff == count_ff) begin
                  count_in = count_ff - CntW'(1);
                  state_in = S_REPLY;
               end else begin
                  addr     = idx_ff;
                  state_in = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (cmd_ff.func == FUNC_INSERT) begin
               addr   = idx_ff;
               idx_in = idx_ff - CntW'(1);
            end else begin
               addr   = idx_ff - CntW'(1);
               idx_in = idx_ff + CntW'(1);
            end
            state_in = S_SHIFT_RD;
         end
         S_REPLY: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[rtl/core/bounded_vector_engine.sv]
// Top level of the bounded vector engine: command queue plus executor.
//
//  channel | direction | tdata fields (low bit up)
//  req     | in        | func[1:0], key[33:2], value[65:34], zero fill to 72
//  rsp     | out       | status[1:0], length[10:2], zero fill to 16
//
// Push and pop are queued, taken by the executor when it is idle, and answered from its reply state.
// Insert and delete search word by word, then move each word with a read and a write,
// all through the single store port.
// Reset clears the count and the queue.
// A stalled response holds the executor; the queue still takes two commands.
`default_nettype none
module bounded_vector_engine
   import bve_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // func, key, value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // status, length
);
   cmd_type    req_cmd, cmd;
   logic       cmd_valid, cmd_take;
   status_type status;
   logic [LenW-1:0] length;

   assign req_cmd.func  = func_type'(req_tdata[1:0]);
   assign req_cmd.key   = req_tdata[33:2];
   assign req_cmd.value = req_tdata[65:34];
   assign rsp_tdata     = {5'd0, length, status};

   bve_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_cmd(req_cmd), .cmd_valid(cmd_valid),
      .cmd_take(cmd_take), .cmd_out(cmd)
   );

   bve_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd_in(cmd), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_status(status), .rsp_length(length)
   );
endmodule
`default_nettype wire

[tb/bve_checker.sv]
// Checker for the bounded vector engine: predicts each response and compares it.
module bve_checker
   import bve_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   output int               fail_count,
   output int               pending,
   output int               rsp_total
);
   typedef struct packed {
      status_type  status;
      logic [8:0]  length;
   } reply_type;

   // Shadow copy of the vector.
   logic [31:0] words [Depth];
   int          word_count;
   reply_type   replies [$];

   // Find the first matching word; returns -1 when the key is absent.
   function automatic int find_word(logic [31:0] k);
      for (int i = 0; i < word_count; i++)
         if (words[i] == k) return i;
      return -1;
   endfunction

   // Apply one command to the shadow vector and return the expected reply.
   function automatic reply_type apply_cmd(logic [71:0] d);
      func_type    f;
      logic [31:0] k;
      logic [31:0] v;
      status_type  st;
      int          pos;
      reply_type   r;
      f  = func_type'(d[1:0]);
      k  = d[33:2];
      v  = d[65:34];
      st = ST_DONE;
      case (f)
         FUNC_PUSH: begin
            if (word_count >= Depth) st = ST_FULL;
            else begin
               words[word_count] = v;
               word_count++;
            end
         end
         FUNC_POP: begin
            if (word_count == 0) st = ST_EMPTY;
            else word_count--;
         end
         FUNC_INSERT: begin
            if (word_count >= Depth) st = ST_FULL;
            else begin
               pos = find_word(k);
               if (pos < 0) st = ST_NOKEY;
               else begin
                  for (int j = word_count; j > pos + 1; j--) words[j] = words[j-1];
                  words[pos+1] = v;
                  word_count++;
               end
            end
         end
         default: begin
            pos = find_word(k);
            if (pos < 0) st = ST_NOKEY;
            else begin
               for (int j = pos + 1; j < word_count; j++) words[j-1] = words[j];
               word_count--;
            end
         end
      endcase
      r.status = st;
      r.length = word_count[8:0];
      return r;
   endfunction

   // Predict on each command transfer, check on each response transfer.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         word_count <= 0;
         fail_count <= 0;
         rsp_total  <= 0;
         replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_total <= rsp_total + 1;
            if (replies.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: response with none expected: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = replies.pop_front();
               if (rsp_tdata[1:0] !== want.status || rsp_tdata[10:2] !== want.length
                   || rsp_tdata[15:11] !== 5'd0) begin
                  if (fail_count < 10)
                     $display("ERROR: status exp %0d got %0d, length exp %0d got %0d",
                              want.status, rsp_tdata[1:0], want.length, rsp_tdata[10:2]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            replies.push_back(apply_cmd(req_tdata));
      end
      pending <= replies.size();
   end
endmodule

[tb/tb_bounded_vector_engine.sv]
// Testbench top for the bounded vector engine: stimulus, flow control and verdict.
module tb_bounded_vector_engine;
   import bve_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;  // func, key, value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;  // status, length
   int          fail_count;
   int          pending;
   int          rsp_total;
   int          idle_cycles;
   int          sent;
   bit          long_hold;
   bit          stall_on;
   logic [31:0] held [$];   // words believed present, used to pick hitting keys

   bounded_vector_engine i_dut (.*);

   bve_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver stall pattern, with one long hold-off when asked.
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < 3000; n++) @(negedge clock);
            long_hold = 1'b0;
         end else if (stall_on)
            rsp_tready <= ($urandom_range(0, 3) != 0);
         else
            rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles with no transfer at all.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("bounded_vector_engine test failed");
         $finish;
      end
   end

   // Send one command and wait for its transfer; tracks likely contents for keys.
   // Valid stays high afterwards so commands can follow back to back.
   task automatic send_cmd(func_type f, logic [31:0] k, logic [31:0] v);
      int p;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, v, k, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      // Coarse mirror, only to steer keys; the checker holds the true state.
      case (f)
         FUNC_PUSH:   if (held.size() < Depth) held.push_back(v);
         FUNC_POP:    if (held.size() > 0) void'(held.pop_back());
         FUNC_INSERT: begin
            if (held.size() < Depth) begin
               p = -1;
               foreach (held[i]) if (p < 0 && held[i] == k) p = i;
               if (p >= 0) held.insert(p + 1, v);
            end
         end
         default: begin
            p = -1;
            foreach (held[i]) if (p < 0 && held[i] == k) p = i;
            if (p >= 0) held.delete(p);
         end
      endcase
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if (held.size() > 0 && $urandom_range(0, 3) != 0)
         return held[$urandom_range(0, held.size() - 1)];
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_word();
      // Small pool to make duplicates and hits likely.
      if ($urandom_range(0, 1)) return $urandom_range(0, 15);
      return $urandom();
   endfunction

   // Stop offering commands and wait until every expected response has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int burst;
      int mode;
      func_type f;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      idle_cycles = 0;
      sent        = 0;
      long_hold   = 1'b0;
      stall_on    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: operations on empty, field extremes, first-match and absent keys.
      send_cmd(FUNC_POP, 0, 0);
      send_cmd(FUNC_INSERT, 0, 1);
      send_cmd(FUNC_DELETE, 0, 0);
      send_cmd(FUNC_PUSH, 0, 32'h8000_0000);
      send_cmd(FUNC_PUSH, 0, 32'h7FFF_FFFF);
      send_cmd(FUNC_PUSH, 0, 32'hFFFF_FFFF);
      send_cmd(FUNC_PUSH, 0, 32'h7FFF_FFFF);
      send_cmd(FUNC_INSERT, 32'h7FFF_FFFF, 32'h0000_0005);
      send_cmd(FUNC_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555);
      send_cmd(FUNC_INSERT, 32'h1234_5678, 32'h5555_AAAA);
      send_cmd(FUNC_DELETE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(FUNC_DELETE, 32'h8000_0000, 0);
      send_cmd(FUNC_DELETE, 32'hAAAA_5555, 0);
      send_cmd(FUNC_DELETE, 32'h0BAD_0BAD, 0);
      send_cmd(FUNC_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Fill to capacity, push and insert against the full store, then delete at both ends and insert.
      for (int i = held.size(); i < Depth; i++) send_cmd(FUNC_PUSH, 0, pick_word());
      send_cmd(FUNC_PUSH, 0, 32'h1);
      send_cmd(FUNC_INSERT, held[0], 32'h2);
      send_cmd(FUNC_INSERT, 32'hDEAD_BEEF, 32'h3);
      send_cmd(FUNC_DELETE, held[Depth-1], 0);
      send_cmd(FUNC_INSERT, held[0], 32'h4);
      send_cmd(FUNC_DELETE, held[0], 0);
      drain();

      // Long receiver hold while commands keep coming.
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++) send_cmd(FUNC_POP, 0, 0);
      drain();

      // Random part: bursts with gaps; content favors hits and moderate size.
      stall_on = 1'b1;
      while (sent < 1170) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            mode = $urandom_range(0, 9);
            if (held.size() > 200 && mode < 4) mode = 4;
            if (mode < 4) f = FUNC_PUSH;
            else if (mode < 5) f = FUNC_POP;
            else if (mode < 7) f = FUNC_INSERT;
            else f = FUNC_DELETE;
            send_cmd(f, pick_key(), pick_word());
         end
         if ($urandom_range(0, 9) == 0) stall_on = ~stall_on;
         if ($urandom_range(0, 1)) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end

      // Drain and let the engine settle.
      drain();
      repeat (3 * Depth + 20) @(negedge clock);
      $display("Covered %0d commands, %0d responses: full, empty, missing-key and shift cases.",
               sent, rsp_total);
      if (fail_count == 0 && pending == 0) $display("bounded_vector_engine test passed");
      else $display("bounded_vector_engine test failed");
      $finish;
   end
endmodule
